FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define AST_CHK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// condition must never be true out of reset
`define AST_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define AST_CHK(label, clk, rst, prop)
`define AST_NEVER(label, clk, rst, cond)
`endif

`endif

FILE: hw/rtl/fbfl_pkg.sv
package fbfl_pkg;

   localparam int MAX_BLOCKS = 255;

   localparam int CMD_W    = 2;
   localparam int IDX_W    = 8;
   localparam int STS_W    = 2;
   localparam int SIZE_W   = 16;
   localparam int OFF_W    = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

   localparam logic [STS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STS_W-1:0] ST_FULL  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = 1'd1;

   localparam logic [IDX_W-1:0]  BLOCK_COUNT_RST = 8'd255;
   localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd64;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [IDX_W-1:0] data;
   } mem_wr_type;

endpackage

FILE: hw/rtl/fbfl_if.sv
interface fbfl_req_if;
   import fbfl_pkg::*;
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [IDX_W-1:0] block_index;
   modport source (output valid, output command, output block_index, input ready);
   modport sink   (input valid, input command, input block_index, output ready);
endinterface

interface fbfl_rsp_if;
   import fbfl_pkg::*;
   logic             valid;
   logic             ready;
   logic [STS_W-1:0] status;
   logic [IDX_W-1:0] granted_index;
   logic [OFF_W-1:0] byte_offset;
   logic [IDX_W-1:0] free_count;
   modport source (output valid, output status, output granted_index,
                   output byte_offset, output free_count, input ready);
   modport sink   (input valid, input status, input granted_index,
                   input byte_offset, input free_count, output ready);
endinterface

interface fbfl_csr_if;
   import fbfl_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/fixed_block_free_list_allocator_unit.sv
// channel  | dir | beat contents
// ---------+-----+-------------------------------------------------------
// req_chan | in  | command, block_index
// rsp_chan | out | status, granted_index, byte_offset, free_count
// csr_chan | in  | index (0 block_count, 1 block_size), data; always ready
//
// Allocate, free and unused commands are accepted, then run in an execute
// state that uses the next-index RAM read issued at accept.
// Init first writes block_count RAM entries, one a cycle, then executes.
// Synchronous reset empties the pool; the RAM contents are not cleared.
// A held result stalls only execute; in idle a new beat is still accepted.
module fixed_block_free_list_allocator_unit (
   input  logic       clock,
   input  logic       reset,
   fbfl_req_if.sink   req_chan,
   fbfl_rsp_if.source rsp_chan,
   fbfl_csr_if.sink   csr_chan
);
   import fbfl_pkg::*;

   logic [IDX_W-1:0]  block_count_ff;
   logic [SIZE_W-1:0] block_size_ff;
   mem_wr_type        mem_wr;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  rd_data;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= BLOCK_COUNT_RST;
         block_size_ff  <= BLOCK_SIZE_RST;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_BLOCK_COUNT: block_count_ff <= csr_chan.data[IDX_W-1:0];
            CSR_BLOCK_SIZE:  block_size_ff  <= csr_chan.data[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   fbfl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .block_count (block_count_ff),
      .block_size  (block_size_ff),
      .mem_wr      (mem_wr),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   fbfl_store u_store (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

FILE: hw/rtl/fbfl_store.sv
module fbfl_store (
   input  logic                       clock,
   input  fbfl_pkg::mem_wr_type       wr,
   input  logic [fbfl_pkg::IDX_W-1:0] rd_addr,
   output logic [fbfl_pkg::IDX_W-1:0] rd_data
);
   import fbfl_pkg::*;

   logic [IDX_W-1:0] store_mem [2**IDX_W];
   logic [IDX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/fbfl_ctrl.sv
`include "assert_macros.svh"

module fbfl_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   fbfl_req_if.sink                    req_chan,
   fbfl_rsp_if.source                  rsp_chan,
   input  logic [fbfl_pkg::IDX_W-1:0]  block_count,
   input  logic [fbfl_pkg::SIZE_W-1:0] block_size,
   output fbfl_pkg::mem_wr_type        mem_wr,
   output logic [fbfl_pkg::IDX_W-1:0]  rd_addr,
   input  logic [fbfl_pkg::IDX_W-1:0]  rd_data
);
   import fbfl_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_INIT = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0] pool_ff, pool_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] n_ff, n_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [STS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [OFF_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [IDX_W-1:0] rsp_count_ff, rsp_count_in;

   logic             accept;
   logic             out_free;
   logic             alloc_ok;
   logic [IDX_W-1:0] n_clamp;
   logic [OFF_W-1:0] product;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign n_clamp  = (32'(block_count) > MAX_BLOCKS) ? IDX_W'(MAX_BLOCKS) : block_count;
   assign product  = OFF_W'(head_ff) * OFF_W'(block_size);
   assign rd_addr  = head_ff;
   assign alloc_ok = (state_ff == S_EXEC) && out_free && (cmd_ff == CMD_ALLOC)
                     && (total_ff != '0);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      pool_in       = pool_ff;
      cnt_in        = cnt_ff;
      n_in          = n_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_chan.command;
               idx_in   = req_chan.block_index;
               n_in     = n_clamp;
               cnt_in   = '0;
               state_in = S_EXEC;
               if (req_chan.command == CMD_INIT && n_clamp != '0) begin
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = cnt_ff;
            mem_wr.data = cnt_ff + 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == n_ff - 1'b1) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_index_in  = '0;
               rsp_offset_in = '0;
               unique case (cmd_ff)
                  CMD_INIT: begin
                     head_in  = '0;
                     total_in = n_ff;
                     pool_in  = n_ff;
                  end
                  CMD_ALLOC: begin
                     if (total_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_index_in  = head_ff;
                        rsp_offset_in = product;
                        head_in       = rd_data;
                        total_in      = total_ff - 1'b1;
                     end
                  end
                  CMD_FREE: begin
                     if (idx_ff >= pool_ff) begin
                        rsp_status_in = ST_RANGE;
                     end else if (total_ff >= pool_ff) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = idx_ff;
                        mem_wr.data = head_ff;
                        head_in     = idx_ff;
                        total_in    = total_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = total_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         total_ff     <= '0;
         pool_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      n_ff          <= n_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.granted_index = rsp_index_ff;
   assign rsp_chan.byte_offset   = rsp_offset_ff;
   assign rsp_chan.free_count    = rsp_count_ff;

   `AST_CHK(a_total_le_pool, clock, reset, total_ff <= pool_ff)
   `AST_CHK(a_alloc_pops, clock, reset, alloc_ok |=> (total_ff == $past(total_ff) - 8'd1))
   `AST_NEVER(a_no_accept_in_walk, clock, reset, (state_ff == S_INIT) && req_chan.ready)
   `AST_CHK(a_held_rsp, clock, reset, (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff)

endmodule
